@@ design/tcpd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcpd_pkg: shared types for the two-class priority dispatcher
// Field widths, request kinds, event types, response status codes, the
// stored entry layout and the controller states.
// ---------------------------------------------------------------------------
package tcpd_pkg;

   localparam int TYPE_W  = 2;
   localparam int INJ_W   = 10;
   localparam int CITY_W  = 8;
   localparam int TIME_W  = 32;
   localparam int ID_W    = 16;
   localparam int SCORE_W = 4;

   localparam logic [TYPE_W-1:0] TYPE_QUAKE = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_FIRE  = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_FLOOD = 2'd2;
   localparam logic [TYPE_W-1:0] TYPE_OTHER = 2'd3;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_SERVE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_QUEUED_URGENT = 3'd0,
      STATUS_QUEUED_NORMAL = 3'd1,
      STATUS_SERVED_URGENT = 3'd2,
      STATUS_SERVED_NORMAL = 3'd3,
      STATUS_NONE          = 3'd4,
      STATUS_DROPPED       = 3'd5
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
      logic [CITY_W-1:0]  city;
      logic [TIME_W-1:0]  stamp;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_NREAD,
      S_SCAN,
      S_SHIFT_START,
      S_SHIFT,
      S_RESULT
   } state_type;

endpackage
`default_nettype wire

@@ design/tcpd_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcpd_if: valid/ready channels of the dispatcher
// Request, response and control-register write channels.
// ---------------------------------------------------------------------------
interface tcpd_req_if import tcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [TYPE_W-1:0]   event_type;
   logic [INJ_W-1:0]    injured_count;
   logic                night;
   logic [CITY_W-1:0]   city_code;
   logic [TIME_W-1:0]   event_time;

   modport source (output valid, kind, event_type, injured_count, night, city_code,
                   event_time, input ready);
   modport sink   (input valid, kind, event_type, injured_count, night, city_code,
                   event_time, output ready);
endinterface

interface tcpd_rsp_if import tcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [ID_W-1:0]     event_id;
   logic [SCORE_W-1:0]  score;
   logic [CITY_W-1:0]   out_city;
   logic [TIME_W-1:0]   out_time;

   modport source (output valid, status, event_id, score, out_city, out_time,
                   input ready);
   modport sink   (input valid, status, event_id, score, out_city, out_time,
                   output ready);
endinterface

interface tcpd_csr_if import tcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SCORE_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ design/tcpd_score.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcpd_score: event priority score
// Base by event type, bonus by injured count and night, capped at ten.
// ---------------------------------------------------------------------------
module tcpd_score import tcpd_pkg::*; (
   input  wire logic [TYPE_W-1:0]  event_type,
   input  wire logic [INJ_W-1:0]   injured_count,
   input  wire logic               night,
   output logic      [SCORE_W-1:0] score
);

   localparam logic [SCORE_W-1:0] SCORE_CAP = 4'd10;
   localparam logic [INJ_W-1:0]   INJ_HIGH  = 10'd10;
   localparam logic [INJ_W-1:0]   INJ_MID   = 10'd5;

   logic [SCORE_W-1:0] base;
   logic [SCORE_W-1:0] inj_bonus;
   logic [SCORE_W:0]   sum;

   always_comb begin
      case (event_type)
         TYPE_QUAKE: base = 4'd5;
         TYPE_FIRE:  base = 4'd4;
         TYPE_FLOOD: base = 4'd3;
         default:    base = 4'd2;
      endcase
      if (injured_count >= INJ_HIGH) begin
         inj_bonus = 4'd3;
      end else if (injured_count >= INJ_MID) begin
         inj_bonus = 4'd2;
      end else if (injured_count != '0) begin
         inj_bonus = 4'd1;
      end else begin
         inj_bonus = 4'd0;
      end
      sum = {1'b0, base} + {1'b0, inj_bonus} + (night ? 5'd2 : 5'd0);
      score = (sum > {1'b0, SCORE_CAP}) ? SCORE_CAP : sum[SCORE_W-1:0];
   end

endmodule
`default_nettype wire

@@ design/two_class_priority_dispatcher_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// two_class_priority_dispatcher_core: scored event queue with FIFO fallback
// Urgent events sit in an arrival-ordered store, the rest in a FIFO ring.
// ---------------------------------------------------------------------------
// One request word at a time. An insert goes from acceptance through the
// insert and result states to the response register. A serve from the FIFO
// ring goes through the ring read and result states. A serve from the urgent
// store first walks the single read port of the urgent memory once over all
// entries to find the best score, then over the slots above the chosen one
// to close the gap. A new request is accepted while a response still waits
// in the output register.
module two_class_priority_dispatcher_core import tcpd_pkg::*; #(
   parameter int URGENT_DEPTH = 16,
   parameter int NORMAL_DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tcpd_req_if.sink   req_chan,
   tcpd_rsp_if.source rsp_chan,
   tcpd_csr_if.sink   csr_chan
);

   localparam int UA = $clog2(URGENT_DEPTH);
   localparam int UC = $clog2(URGENT_DEPTH + 1);
   localparam int NA = $clog2(NORMAL_DEPTH);
   localparam int NC = $clog2(NORMAL_DEPTH + 1);
   localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 4'd5;

   state_type          state_ff, state_in;
   logic [SCORE_W-1:0] thr_ff, thr_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   entry_type          item_ff, item_in;
   logic [UC-1:0]      ucount_ff, ucount_in;
   logic [UA-1:0]      scan_idx_ff, scan_idx_in;
   logic [UA-1:0]      best_idx_ff, best_idx_in;
   logic [UA-1:0]      shift_idx_ff, shift_idx_in;
   entry_type          best_ff, best_in;
   logic [NA-1:0]      head_ff, head_in;
   logic [NA-1:0]      tail_ff, tail_in;
   logic [NC-1:0]      ncount_ff, ncount_in;
   status_type         res_status_ff, res_status_in;
   entry_type          res_entry_ff, res_entry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   entry_type          rsp_entry_ff, rsp_entry_in;

   entry_type          urgent_mem [URGENT_DEPTH];
   entry_type          normal_mem [NORMAL_DEPTH];
   entry_type          urgent_rd_ff;
   entry_type          normal_rd_ff;

   logic               u_we;
   logic [UA-1:0]      u_waddr;
   logic [UA-1:0]      u_raddr;
   entry_type          u_wdata;
   logic               n_we;

   logic [SCORE_W-1:0] new_score;
   logic               req_fire;
   logic               rsp_free;
   logic               scan_last;
   logic               best_last;
   logic               shift_last;
   logic               take_best;
   logic [NA-1:0]      head_next;
   logic [NA-1:0]      tail_next;

   tcpd_score u_score (
      .event_type    (req_chan.event_type),
      .injured_count (req_chan.injured_count),
      .night         (req_chan.night),
      .score         (new_score)
   );

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign scan_last  = (UC'(scan_idx_ff) == ucount_ff - UC'(1));
   assign best_last  = (UC'(best_idx_ff) == ucount_ff - UC'(1));
   assign shift_last = (UC'(shift_idx_ff) + UC'(2) == ucount_ff);
   assign take_best  = (scan_idx_ff == '0) || (urgent_rd_ff.score > best_ff.score);
   assign head_next  = (head_ff == NA'(NORMAL_DEPTH - 1)) ? '0 : head_ff + NA'(1);
   assign tail_next  = (tail_ff == NA'(NORMAL_DEPTH - 1)) ? '0 : tail_ff + NA'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_INSERT) begin
                  state_in = S_INSERT;
               end else if (ucount_ff != '0) begin
                  state_in = S_SCAN;
               end else if (ncount_ff != '0) begin
                  state_in = S_NREAD;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_INSERT:      state_in = S_RESULT;
         S_NREAD:       state_in = S_RESULT;
         S_SCAN:        state_in = scan_last ? S_SHIFT_START : S_SCAN;
         S_SHIFT_START: state_in = best_last ? S_RESULT : S_SHIFT;
         S_SHIFT:       state_in = shift_last ? S_RESULT : S_SHIFT;
         S_RESULT:      state_in = rsp_free ? S_IDLE : S_RESULT;
         default:       state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready   = (state_ff == S_IDLE);
      csr_chan.ready   = 1'b1;
      rsp_chan.valid   = rsp_valid_ff;
      rsp_chan.status  = rsp_status_ff;
      rsp_chan.event_id = rsp_entry_ff.id;
      rsp_chan.score   = rsp_entry_ff.score;
      rsp_chan.out_city = rsp_entry_ff.city;
      rsp_chan.out_time = rsp_entry_ff.stamp;
   end

   always_comb begin
      thr_in        = thr_ff;
      next_id_in    = next_id_ff;
      item_in       = item_ff;
      ucount_in     = ucount_ff;
      scan_idx_in   = scan_idx_ff;
      best_idx_in   = best_idx_ff;
      shift_idx_in  = shift_idx_ff;
      best_in       = best_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      ncount_in     = ncount_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      u_we          = 1'b0;
      u_waddr       = ucount_ff[UA-1:0];
      u_wdata       = item_ff;
      u_raddr       = '0;
      n_we          = 1'b0;

      if (csr_chan.valid && csr_chan.ready) begin
         thr_in = csr_chan.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            scan_idx_in = '0;
            if (req_fire) begin
               if (req_chan.kind == KIND_INSERT) begin
                  next_id_in    = next_id_ff + ID_W'(1);
                  item_in.id    = next_id_ff + ID_W'(1);
                  item_in.score = new_score;
                  item_in.city  = req_chan.city_code;
                  item_in.stamp = req_chan.event_time;
               end else begin
                  res_status_in = STATUS_NONE;
                  res_entry_in  = '0;
               end
            end
         end
         S_INSERT: begin
            res_entry_in       = '0;
            res_entry_in.id    = item_ff.id;
            res_entry_in.score = item_ff.score;
            if (item_ff.score >= thr_ff) begin
               if (ucount_ff == UC'(URGENT_DEPTH)) begin
                  res_status_in = STATUS_DROPPED;
               end else begin
                  u_we          = 1'b1;
                  ucount_in     = ucount_ff + UC'(1);
                  res_status_in = STATUS_QUEUED_URGENT;
               end
            end else begin
               if (ncount_ff == NC'(NORMAL_DEPTH)) begin
                  res_status_in = STATUS_DROPPED;
               end else begin
                  n_we          = 1'b1;
                  tail_in       = tail_next;
                  ncount_in     = ncount_ff + NC'(1);
                  res_status_in = STATUS_QUEUED_NORMAL;
               end
            end
         end
         S_NREAD: begin
            res_entry_in  = normal_rd_ff;
            res_status_in = STATUS_SERVED_NORMAL;
            head_in       = head_next;
            ncount_in     = ncount_ff - NC'(1);
         end
         S_SCAN: begin
            if (take_best) begin
               best_in     = urgent_rd_ff;
               best_idx_in = scan_idx_ff;
            end
            scan_idx_in = scan_idx_ff + UA'(1);
            u_raddr     = scan_idx_ff + UA'(1);
         end
         S_SHIFT_START: begin
            u_raddr      = best_idx_ff + UA'(1);
            shift_idx_in = best_idx_ff;
            if (best_last) begin
               ucount_in     = ucount_ff - UC'(1);
               res_entry_in  = best_ff;
               res_status_in = STATUS_SERVED_URGENT;
            end
         end
         S_SHIFT: begin
            u_we         = 1'b1;
            u_waddr      = shift_idx_ff;
            u_wdata      = urgent_rd_ff;
            u_raddr      = shift_idx_ff + UA'(2);
            shift_idx_in = shift_idx_ff + UA'(1);
            if (shift_last) begin
               ucount_in     = ucount_ff - UC'(1);
               res_entry_in  = best_ff;
               res_status_in = STATUS_SERVED_URGENT;
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (u_we) begin
         urgent_mem[u_waddr] <= u_wdata;
      end
      urgent_rd_ff <= urgent_mem[u_raddr];
   end

   always_ff @(posedge clock) begin
      if (n_we) begin
         normal_mem[tail_ff] <= item_ff;
      end
      normal_rd_ff <= normal_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         next_id_ff   <= '0;
         ucount_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         ncount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         next_id_ff   <= next_id_in;
         ucount_ff    <= ucount_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ncount_ff    <= ncount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      scan_idx_ff   <= scan_idx_in;
      best_idx_ff   <= best_idx_in;
      shift_idx_ff  <= shift_idx_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

endmodule
`default_nettype wire
